// ===== sv/q4bq_pkg.sv =====
package q4bq_pkg;

  localparam int unsigned STORE_DEPTH    = 256;
  localparam int unsigned DEF_BLOCK_SIZE = 256;
  localparam int unsigned WORDS_OUT      = 36;
  localparam int unsigned HEAD_WORDS     = 4;
  localparam int unsigned NIBS_PER_WORD  = 8;
  localparam int unsigned FILL_W         = $clog2(STORE_DEPTH + 1);
  localparam int unsigned ADDR_W         = $clog2(STORE_DEPTH);
  localparam int unsigned WCNT_W         = $clog2(WORDS_OUT);

  localparam logic [31:0] F_ZERO     = 32'h0000_0000;
  localparam logic [31:0] F_ONE      = 32'h3F80_0000;
  localparam logic [31:0] F_FIFTEEN  = 32'h4170_0000;
  localparam logic [31:0] F_TINY     = 32'h2EDB_E6FF;
  localparam logic [31:0] F_QNAN     = 32'h7FC0_0000;
  localparam logic [31:0] F_PINF     = 32'h7F80_0000;
  localparam logic [31:0] F_FRAC_MSK = 32'h007F_FFFF;
  localparam logic [15:0] H_SIGN     = 16'h8000;
  localparam logic [15:0] H_INF      = 16'h7C00;

  // ceil(2^34 / 15): exact floor quotient for dividends below 2^30
  localparam logic [30:0] RCP15 = 31'd1145324613;

  // y scaled by 2^25: 14.5 and 0.5 thresholds
  localparam logic [29:0] Q_TOP  = 30'd486539264;
  localparam logic [29:0] Q_HALF = 30'd16777216;

  typedef struct packed {
    logic [31:0] weight_bits;
    logic        block_end;
  } weight_item_t;

  typedef struct packed {
    logic [31:0] packed_word;
    logic        last_word;
  } word_item_t;

  typedef enum logic [3:0] {
    ST_LOAD,
    ST_PAD,
    ST_RANGE,
    ST_RWAIT,
    ST_DIV1,
    ST_DIV2,
    ST_EMIT,
    ST_ISSUE,
    ST_DRAIN
  } state_t;

  typedef struct packed {
    logic        special;
    logic [31:0] spec_val;
    logic        eff_sub;
    logic        sign;
    logic [7:0]  exp;
    logic [26:0] ma;
    logic [26:0] mb;
  } add_a_t;

  typedef struct packed {
    logic        special;
    logic [31:0] spec_val;
    logic        sign;
    logic [7:0]  exp;
    logic [27:0] sum;
  } add_b_t;

  typedef struct packed {
    logic        special;
    logic [31:0] spec_val;
    logic        sign;
    logic        zero;
    logic [9:0]  exp;
    logic [26:0] mant;
  } add_c_t;

  typedef struct packed {
    logic        force_on;
    logic [3:0]  force_q;
    logic [9:0]  ue;
    logic [47:0] prod;
  } mul_t;

  function automatic logic is_nan(input logic [31:0] f);
    return (f[30:23] == 8'hFF) && ((f & F_FRAC_MSK) != 32'h0);
  endfunction

  function automatic logic is_inf(input logic [31:0] f);
    return (f[30:23] == 8'hFF) && ((f & F_FRAC_MSK) == 32'h0);
  endfunction

  // ordered a > b, false when either is nan, signed zeros equal
  function automatic logic fp_gt(input logic [31:0] a, input logic [31:0] b);
    logic r;
    if (is_nan(a) || is_nan(b)) begin
      r = 1'b0;
    end else if (a[30:0] == 31'h0 && b[30:0] == 31'h0) begin
      r = 1'b0;
    end else if (a[31] != b[31]) begin
      r = ~a[31];
    end else if (!a[31]) begin
      r = a[30:0] > b[30:0];
    end else begin
      r = a[30:0] < b[30:0];
    end
    return r;
  endfunction

  // a - b: unpack, order by magnitude, align the smaller with sticky
  function automatic add_a_t add_align(input logic [31:0] a, input logic [31:0] b);
    add_a_t      r;
    logic [31:0] nb;
    logic [31:0] big;
    logic [31:0] sml;
    logic [7:0]  e_big;
    logic [7:0]  e_sml;
    logic [7:0]  d;
    logic [23:0] m_big;
    logic [23:0] m_sml;
    logic [53:0] wide;
    logic [26:0] sh;
    logic        stk;
    nb = {~b[31], b[30:0]};
    r = '0;
    r.special = is_nan(a) || is_nan(nb) || is_inf(a) || is_inf(nb);
    if (is_nan(a) || is_nan(nb)) begin
      r.spec_val = F_QNAN;
    end else if (is_inf(a) && is_inf(nb)) begin
      r.spec_val = (a[31] != nb[31]) ? F_QNAN : a;
    end else if (is_inf(a)) begin
      r.spec_val = a;
    end else begin
      r.spec_val = nb;
    end
    if (a[30:0] >= nb[30:0]) begin
      big = a;
      sml = nb;
    end else begin
      big = nb;
      sml = a;
    end
    e_big = (big[30:23] == 8'h0) ? 8'd1 : big[30:23];
    e_sml = (sml[30:23] == 8'h0) ? 8'd1 : sml[30:23];
    m_big = {big[30:23] != 8'h0, big[22:0]};
    m_sml = {sml[30:23] != 8'h0, sml[22:0]};
    d = e_big - e_sml;
    if (d >= 8'd27) begin
      sh  = '0;
      stk = |m_sml;
    end else begin
      wide = {m_sml, 3'b000, 27'h0} >> d;
      sh   = wide[53:27];
      stk  = |wide[26:0];
    end
    r.ma      = {m_big, 3'b000};
    r.mb      = {sh[26:1], sh[0] | stk};
    r.eff_sub = a[31] ^ nb[31];
    r.sign    = big[31];
    r.exp     = e_big;
    return r;
  endfunction

  function automatic add_b_t add_sum(input add_a_t s);
    add_b_t r;
    r.special  = s.special;
    r.spec_val = s.spec_val;
    r.sign     = s.sign;
    r.exp      = s.exp;
    r.sum      = s.eff_sub ? ({1'b0, s.ma} - {1'b0, s.mb}) : ({1'b0, s.ma} + {1'b0, s.mb});
    return r;
  endfunction

  // results below the normal range are flushed, nothing downstream can tell
  function automatic add_c_t add_norm(input add_b_t s);
    add_c_t             r;
    logic [4:0]         lz;
    logic signed [9:0]  e;
    r.special  = s.special;
    r.spec_val = s.spec_val;
    r.sign     = s.sign;
    lz = 5'd27;
    for (int i = 0; i < 27; i++) begin
      if (s.sum[i]) lz = 5'(26 - i);
    end
    if (s.sum[27]) begin
      r.mant = {s.sum[27:2], s.sum[1] | s.sum[0]};
      r.exp  = {2'b00, s.exp} + 10'd1;
      r.zero = 1'b0;
    end else begin
      r.mant = s.sum[26:0] << lz;
      e      = $signed({2'b00, s.exp}) - $signed({5'b00000, lz});
      r.exp  = e;
      r.zero = (lz == 5'd27) || (e < 10'sd1);
    end
    return r;
  endfunction

  function automatic logic [31:0] add_round(input add_c_t c);
    logic        up;
    logic [24:0] m;
    logic [9:0]  e;
    logic [31:0] r;
    up = c.mant[2] & (c.mant[1] | c.mant[0] | c.mant[3]);
    m  = {1'b0, c.mant[26:3]} + 25'(up);
    e  = c.exp + 10'(m[24]);
    if (c.special) begin
      r = c.spec_val;
    end else if (c.zero) begin
      r = F_ZERO;
    end else if ($signed(e) >= 10'sd255) begin
      r = {c.sign, 8'hFF, 23'h0};
    end else begin
      r = {c.sign, e[7:0], m[22:0]};
    end
    return r;
  endfunction

  // inv is +0 or a positive normal; every other outcome settles the code early
  function automatic mul_t mul_prep(input logic [31:0] d, input logic [31:0] inv);
    mul_t        r;
    logic [23:0] x;
    logic [23:0] y;
    r = '0;
    r.force_on = 1'b1;
    x = {1'b1, d[22:0]};
    y = {1'b1, inv[22:0]};
    if (inv[30:0] == 31'h0 || is_nan(d) || d[31]) begin
      r.force_q = 4'd0;
    end else if (is_inf(d)) begin
      r.force_q = 4'd15;
    end else if (d[30:23] == 8'h0) begin
      r.force_q = 4'd0;
    end else begin
      r.force_on = 1'b0;
      r.prod     = {24'h0, x} * {24'h0, y};
      r.ue       = {2'b00, d[30:23]} + {2'b00, inv[30:23]} - 10'd254;
    end
    return r;
  endfunction

  // round the product to single, then round half away and clamp to 0..15
  function automatic logic [3:0] quant(input mul_t m);
    logic [23:0]       mant;
    logic              g;
    logic              s;
    logic              up;
    logic [24:0]       mr;
    logic signed [9:0] e;
    logic [2:0]        sa;
    logic [29:0]       y;
    logic [29:0]       t;
    logic [3:0]        q;
    if (m.prod[47]) begin
      mant = m.prod[47:24];
      g    = m.prod[23];
      s    = |m.prod[22:0];
      e    = $signed(m.ue) + 10'sd1;
    end else begin
      mant = m.prod[46:23];
      g    = m.prod[22];
      s    = |m.prod[21:0];
      e    = $signed(m.ue);
    end
    up = g & (s | mant[0]);
    mr = {1'b0, mant} + 25'(up);
    sa = 3'(e + 10'sd2);
    y  = 30'(mr) << sa;
    t  = y + Q_HALF;
    if (m.force_on) begin
      q = m.force_q;
    end else if (e >= 10'sd4) begin
      q = 4'd15;
    end else if (e <= -10'sd3) begin
      q = 4'd0;
    end else if (y >= Q_TOP) begin
      q = 4'd15;
    end else if (y < Q_HALF) begin
      q = 4'd0;
    end else begin
      q = t[28:25];
    end
    return q;
  endfunction

  function automatic logic [15:0] half_of(input logic [31:0] f);
    logic [7:0]  e;
    logic [15:0] sgn;
    logic [15:0] r;
    e   = f[30:23];
    sgn = f[31] ? H_SIGN : 16'h0;
    if (e <= 8'd112) begin
      r = sgn;
    end else if (e >= 8'd143) begin
      r = sgn | H_INF;
    end else begin
      r = sgn | {1'b0, 5'(e - 8'd112), f[22:13]};
    end
    return r;
  endfunction

endpackage

// ===== sv/q4_block_min_scale_quantizer.sv =====
// 4-bit min/scale block quantizer.
// weight channel (valid/ready): one fp32 weight per word, block_end closes the
// block early; positions not filled count as +0.0. A block also closes when
// BLOCK_SIZE weights have arrived. Weights load at one per cycle.
// word channel (valid/ready): 36 words per block, last_word on the last one.
// Word 0 holds the fp16 scale and min, words 1..3 are zero, words 4..35 carry
// the packed nibble pairs.
// After the closing weight the block works out range, scale and its reciprocal
// (pad, the subtract pipeline, a divide by fifteen, a restoring divider); the
// divide by fifteen is skipped when the range is tiny. The three zero words
// follow one per cycle while the receiver is ready. For each data word, eight
// reads of the weight memory, one per cycle, flow through the subtract,
// multiply and rounding stages; the word waits for all eight nibbles.
// No weight is taken from the closing weight until the last word is accepted.
// A stalled receiver simply holds the current word; nothing is lost.
// rst (synchronous) clears the fill count and sets the running max and min to
// +0.0; the weight memory is not cleared.
module q4_block_min_scale_quantizer
  import q4bq_pkg::*;
#(
  parameter int unsigned BLOCK_SIZE = DEF_BLOCK_SIZE
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         weight_valid,
  output logic         weight_ready,
  input  weight_item_t weight,
  output logic         word_valid,
  input  logic         word_ready,
  output word_item_t   word
);

  logic [31:0] mem [STORE_DEPTH];

  state_t state;
  state_t state_next;

  logic [FILL_W-1:0] fill_count;
  logic [31:0]       run_max;
  logic [31:0]       run_min;
  logic [31:0]       scale;
  logic [31:0]       inv;
  logic [31:0]       out_word;
  logic [WCNT_W-1:0] wcnt;
  logic [2:0]        ncnt;
  logic [3:0]        nib_cnt;
  logic [31:0]       nib_word;

  // pipeline
  logic        rd_v;
  logic        rd_pad;
  logic [31:0] rdata;
  logic        a_v, a_tag;
  add_a_t      a_s;
  logic        b_v, b_tag;
  add_b_t      b_s;
  logic        c_v, c_tag;
  add_c_t      c_s;
  logic        d_v, d_tag;
  logic [31:0] d_res;
  logic        m_v;
  mul_t        m_s;
  logic        q_v;
  logic [3:0]  q_nib;

  // divider
  logic              div_busy;
  logic              div_done;
  logic [4:0]        div_cnt;
  logic [25:0]       div_rem;
  logic [23:0]       div_mb;
  logic [24:0]       div_q;
  logic [9:0]        div_exp;
  logic [31:0]       div_res;
  logic              div_up;
  logic [24:0]       div_m;
  logic [9:0]        div_e;

  // range / 15
  logic              c15_start;
  logic              c15_v1;
  logic              c15_v2;
  logic              c15_v3;
  logic [29:0]       c15_nv;
  logic [29:0]       c15_n;
  logic [7:0]        c15_e;
  logic              c15_inf;
  logic [60:0]       c15_prod;
  logic [26:0]       c15_q;
  logic              c15_rnz;
  logic [23:0]       c15_mant;
  logic              c15_g;
  logic              c15_s;
  logic [24:0]       c15_m;
  logic [7:0]        c15_x;
  logic [31:0]       c15_res;

  // control from the state machine
  logic        load_acc;
  logic        close_now;
  logic        pad_step;
  logic        range_go;
  logic        div_start;
  logic [31:0] div_a;
  logic [31:0] div_b;
  logic        scale_load;
  logic [31:0] scale_val;
  logic        inv_load;
  logic        hdr_load;
  logic        zero_load;
  logic        word_load;
  logic        nib_clear;
  logic        issue;
  logic        finish;
  logic        wcnt_inc;

  logic [4:0]        kidx;
  logic [ADDR_W-1:0] rd_addr;
  logic [31:0]       x_in;
  logic [31:0]       a_in;
  logic              a_in_v;

  assign kidx    = 5'(wcnt - WCNT_W'(HEAD_WORDS));
  // nibble n of word k: byte n/2, high half when n is odd
  assign rd_addr = {kidx[4:2], ncnt[0], kidx[1:0], ncnt[2:1]};
  assign close_now = weight.block_end || ((fill_count + FILL_W'(1)) >= FILL_W'(BLOCK_SIZE));

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_LOAD;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next   = state;
    weight_ready = 1'b0;
    word_valid   = 1'b0;
    load_acc     = 1'b0;
    pad_step     = 1'b0;
    range_go     = 1'b0;
    div_start    = 1'b0;
    c15_start    = 1'b0;
    div_a        = F_ONE;
    div_b        = F_ONE;
    scale_load   = 1'b0;
    scale_val    = F_TINY;
    inv_load     = 1'b0;
    hdr_load     = 1'b0;
    zero_load    = 1'b0;
    word_load    = 1'b0;
    nib_clear    = 1'b0;
    issue        = 1'b0;
    finish       = 1'b0;
    wcnt_inc     = 1'b0;
    unique case (state)
      ST_LOAD: begin
        weight_ready = 1'b1;
        if (weight_valid) begin
          load_acc = 1'b1;
          if (close_now) state_next = ST_PAD;
        end
      end
      ST_PAD: begin
        pad_step   = 1'b1;
        state_next = ST_RANGE;
      end
      ST_RANGE: begin
        range_go   = 1'b1;
        state_next = ST_RWAIT;
      end
      ST_RWAIT: begin
        if (d_v && d_tag) begin
          if (fp_gt(d_res, F_TINY)) begin
            c15_start  = 1'b1;
            state_next = ST_DIV1;
          end else begin
            div_start  = 1'b1;
            scale_load = 1'b1;
            scale_val  = F_TINY;
            div_a      = F_ONE;
            div_b      = F_TINY;
            state_next = ST_DIV2;
          end
        end
      end
      ST_DIV1: begin
        if (c15_v3) begin
          scale_load = 1'b1;
          scale_val  = c15_res;
          div_start  = 1'b1;
          div_a      = F_ONE;
          div_b      = c15_res;
          state_next = ST_DIV2;
        end
      end
      ST_DIV2: begin
        if (div_done) begin
          inv_load   = 1'b1;
          hdr_load   = 1'b1;
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        word_valid = 1'b1;
        if (word_ready) begin
          if (wcnt == WCNT_W'(WORDS_OUT - 1)) begin
            finish     = 1'b1;
            state_next = ST_LOAD;
          end else begin
            wcnt_inc = 1'b1;
            if ((wcnt + WCNT_W'(1)) < WCNT_W'(HEAD_WORDS)) begin
              zero_load = 1'b1;
            end else begin
              nib_clear  = 1'b1;
              state_next = ST_ISSUE;
            end
          end
        end
      end
      ST_ISSUE: begin
        issue = 1'b1;
        if (ncnt == 3'(NIBS_PER_WORD - 1)) state_next = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (nib_cnt == 4'(NIBS_PER_WORD)) begin
          word_load  = 1'b1;
          state_next = ST_EMIT;
        end
      end
      default: state_next = ST_LOAD;
    endcase
  end

  // weight memory, one write and one registered read port
  always_ff @(posedge clk) begin
    if (load_acc) mem[fill_count[ADDR_W-1:0]] <= weight.weight_bits;
    if (issue) rdata <= mem[rd_addr];
  end

  // block statistics and output word
  always_ff @(posedge clk) begin
    if (rst) begin
      fill_count <= '0;
      run_max    <= F_ZERO;
      run_min    <= F_ZERO;
      wcnt       <= '0;
      ncnt       <= '0;
      nib_cnt    <= '0;
    end else begin
      if (load_acc) begin
        fill_count <= fill_count + FILL_W'(1);
        run_max    <= fp_gt(run_max, weight.weight_bits) ? run_max : weight.weight_bits;
        run_min    <= fp_gt(weight.weight_bits, run_min) ? run_min : weight.weight_bits;
      end else if (pad_step && fill_count < FILL_W'(STORE_DEPTH)) begin
        run_max <= fp_gt(run_max, F_ZERO) ? run_max : F_ZERO;
        run_min <= fp_gt(F_ZERO, run_min) ? run_min : F_ZERO;
      end else if (finish) begin
        fill_count <= '0;
        run_max    <= F_ZERO;
        run_min    <= F_ZERO;
      end
      if (hdr_load) begin
        wcnt <= '0;
      end else if (finish) begin
        wcnt <= '0;
      end else if (wcnt_inc) begin
        wcnt <= wcnt + WCNT_W'(1);
      end
      if (nib_clear) begin
        ncnt    <= '0;
        nib_cnt <= '0;
      end else begin
        if (issue) ncnt <= ncnt + 3'd1;
        if (q_v) nib_cnt <= nib_cnt + 4'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (scale_load) scale <= scale_val;
    if (inv_load) inv <= div_res;
    if (hdr_load) begin
      out_word <= {half_of(run_min), half_of(scale)};
    end else if (zero_load) begin
      out_word <= '0;
    end else if (word_load) begin
      out_word <= nib_word;
    end
    if (q_v) nib_word <= {q_nib, nib_word[31:4]};
  end

  assign word = '{packed_word: out_word, last_word: (wcnt == WCNT_W'(WORDS_OUT - 1))};

  // subtract, multiply and rounding pipeline
  assign x_in   = rd_pad ? F_ZERO : rdata;
  assign a_in   = range_go ? run_max : x_in;
  assign a_in_v = rd_v | range_go;

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_v  <= 1'b0;
      a_v   <= 1'b0;
      a_tag <= 1'b0;
      b_v   <= 1'b0;
      b_tag <= 1'b0;
      c_v   <= 1'b0;
      c_tag <= 1'b0;
      d_v   <= 1'b0;
      d_tag <= 1'b0;
      m_v   <= 1'b0;
      q_v   <= 1'b0;
    end else begin
      rd_v  <= issue;
      a_v   <= a_in_v;
      a_tag <= range_go;
      b_v   <= a_v;
      b_tag <= a_tag;
      c_v   <= b_v;
      c_tag <= b_tag;
      d_v   <= c_v;
      d_tag <= c_tag;
      m_v   <= d_v & ~d_tag;
      q_v   <= m_v;
    end
  end

  always_ff @(posedge clk) begin
    rd_pad <= {1'b0, rd_addr} >= fill_count;
    a_s    <= add_align(a_in, run_min);
    b_s    <= add_sum(a_s);
    c_s    <= add_norm(b_s);
    d_res  <= add_round(c_s);
    m_s    <= mul_prep(d_res, inv);
    q_nib  <= quant(m_s);
  end

  // range / 15 for a positive normal or infinite range: floor quotient of the
  // mantissa shifted up by six through the reciprocal, then nearest even
  assign c15_nv   = {1'b1, d_res[22:0], 6'b000000};
  assign c15_mant = c15_q[26] ? c15_q[26:3] : c15_q[25:2];
  assign c15_g    = c15_q[26] ? c15_q[2] : c15_q[1];
  assign c15_s    = (c15_q[26] ? (|c15_q[1:0]) : c15_q[0]) | c15_rnz;
  assign c15_m    = {1'b0, c15_mant} + 25'(c15_g & (c15_s | c15_mant[0]));
  assign c15_x    = c15_e - (c15_q[26] ? 8'd3 : 8'd4) + 8'(c15_m[24]);

  always_ff @(posedge clk) begin
    if (rst) begin
      c15_v1 <= 1'b0;
      c15_v2 <= 1'b0;
      c15_v3 <= 1'b0;
    end else begin
      c15_v1 <= c15_start;
      c15_v2 <= c15_v1;
      c15_v3 <= c15_v2;
    end
  end

  always_ff @(posedge clk) begin
    if (c15_start) begin
      c15_n    <= c15_nv;
      c15_e    <= d_res[30:23];
      c15_inf  <= d_res[30:23] == 8'hFF;
      c15_prod <= {31'h0, c15_nv} * {30'h0, RCP15};
    end
    if (c15_v1) begin
      c15_q   <= c15_prod[60:34];
      // the remainder is non-zero unless fifteen times the quotient is exact
      c15_rnz <= c15_n != 30'({c15_prod[60:34], 4'h0} - {4'h0, c15_prod[60:34]});
    end
    if (c15_v2) c15_res <= c15_inf ? F_PINF : {1'b0, c15_x, c15_m[22:0]};
  end

  // restoring divider for positive normal operands, one quotient bit a cycle
  assign div_up = div_q[0] & ((div_rem != 26'h0) | div_q[1]);
  assign div_m  = {1'b0, div_q[24:1]} + 25'(div_up);
  assign div_e  = div_exp + 10'(div_m[24]);

  always_ff @(posedge clk) begin
    if (rst) begin
      div_busy <= 1'b0;
      div_done <= 1'b0;
      div_cnt  <= '0;
    end else begin
      div_done <= 1'b0;
      if (div_start) begin
        if (div_a[30:23] == 8'hFF) begin
          div_done <= 1'b1;
        end else if (div_b[30:23] == 8'hFF) begin
          div_done <= 1'b1;
        end else begin
          div_busy <= 1'b1;
          div_cnt  <= 5'd25;
        end
      end else if (div_busy) begin
        if (div_cnt == 5'd0) begin
          div_busy <= 1'b0;
          div_done <= 1'b1;
        end else begin
          div_cnt <= div_cnt - 5'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (div_start) begin
      div_q  <= '0;
      div_mb <= {1'b1, div_b[22:0]};
      if (div_a[30:23] == 8'hFF) begin
        div_res <= F_PINF;
      end else if (div_b[30:23] == 8'hFF) begin
        div_res <= F_ZERO;
      end
      if ({1'b1, div_a[22:0]} < {1'b1, div_b[22:0]}) begin
        div_rem <= {1'b0, 1'b1, div_a[22:0], 1'b0};
        div_exp <= {2'b00, div_a[30:23]} - {2'b00, div_b[30:23]} + 10'd126;
      end else begin
        div_rem <= {2'b00, 1'b1, div_a[22:0]};
        div_exp <= {2'b00, div_a[30:23]} - {2'b00, div_b[30:23]} + 10'd127;
      end
    end else if (div_busy) begin
      if (div_cnt == 5'd0) begin
        div_res <= {1'b0, div_e[7:0], div_m[22:0]};
      end else if (div_rem >= {2'b00, div_mb}) begin
        div_rem <= 26'(div_rem - {2'b00, div_mb}) << 1;
        div_q   <= {div_q[23:0], 1'b1};
      end else begin
        div_rem <= div_rem << 1;
        div_q   <= {div_q[23:0], 1'b0};
      end
    end
  end

  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(weight_ready && word_valid))
    else $error("weight taken while a packed word is offered");

  a_nib_bound: assert property (@(posedge clk) disable iff (rst)
    nib_cnt <= 4'(NIBS_PER_WORD))
    else $error("more nibbles gathered than one word holds");

  a_range_tag: assert property (@(posedge clk) disable iff (rst)
    (d_v && d_tag) |-> (state == ST_RWAIT))
    else $error("range result arrived outside its wait");

  a_block_restart: assert property (@(posedge clk) disable iff (rst)
    (word_valid && word_ready && word.last_word) |=> (weight_ready && fill_count == '0))
    else $error("block state not cleared after the last word");

endmodule
